// ----- design/hcbd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types, constants and helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  localparam int unsigned CAP_W     = 18;
  localparam int unsigned COUNT_W   = 17;
  localparam int unsigned SIZE_W    = 32;
  localparam logic [CAP_W-1:0]   CAP_MAX       = 18'd131072;
  localparam logic [COUNT_W-1:0] CAP_LIMIT_MAX = 17'd131071;

  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [3:0] HEX_TEN = 4'd10;

  typedef enum logic [2:0] {
    PH_LINE_START = 3'd0,
    PH_LINE_IN    = 3'd1,
    PH_SKIP_SIZE  = 3'd2,
    PH_DATA       = 3'd3,
    PH_SKIP_DATA  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       start_of_body;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_end;
    logic       saw_zero_chunk;
    logic       truncated;
  } out_item_t;

  typedef struct packed {
    phase_t              phase;
    logic [SIZE_W-1:0]   size_or_remaining;
    logic [COUNT_W-1:0]  written_count;
    logic                overflow_seen;
    logic                finished;
  } dec_state_t;

  localparam dec_state_t STATE_CLEAR = '{
    phase:             PH_LINE_START,
    size_or_remaining: '0,
    written_count:     '0,
    overflow_seen:     1'b0,
    finished:          1'b0
  };

  // non-hex characters give a zero digit
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
    end else if (c >= CH_LA && c <= CH_LF_HEX) begin
      d = c - CH_LA + {4'd0, HEX_TEN};
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = c - CH_UA + {4'd0, HEX_TEN};
    end
    return d[3:0];
  endfunction

endpackage

// ----- design/hcbd_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_step
// Per-byte decoder update: next state and the optional result for one byte.
// ----------------------------------------------------------------------------
module hcbd_step
  import hcbd_pkg::*;
(
  input  dec_state_t         cur,
  input  in_item_t           item,
  input  logic [COUNT_W-1:0] cap_limit,
  output dec_state_t         nxt,
  output logic               res_valid,
  output out_item_t          res
);

  dec_state_t          st;
  logic [7:0]          c;
  logic                is_nul;
  logic                crlf;
  logic                room;
  logic [SIZE_W-1:0]   size_dec;
  logic [3:0]          digit;

  always_comb begin
    st       = item.start_of_body ? STATE_CLEAR : cur;
    c        = item.body_byte;
    is_nul   = (c == CH_NUL);
    crlf     = (c == CH_CR) || (c == CH_LF);
    room     = (st.written_count < cap_limit);
    size_dec = st.size_or_remaining - SIZE_W'(1);
    digit    = hex_value(c);
  end

  // next state
  always_comb begin
    nxt = st;
    if (!st.finished) begin
      case (st.phase)
        PH_LINE_START, PH_LINE_IN: begin
          if (is_nul) begin
            nxt.finished = 1'b1;
          end else if (crlf) begin
            if (st.size_or_remaining == '0) nxt.finished = 1'b1;
            else nxt.phase = PH_SKIP_SIZE;
          end else begin
            nxt.size_or_remaining = {st.size_or_remaining[SIZE_W-5:0], digit};
            nxt.phase = PH_LINE_IN;
          end
        end
        PH_SKIP_SIZE, PH_DATA: begin
          if (is_nul) begin
            nxt.finished = 1'b1;
          end else if (!(crlf && st.phase == PH_SKIP_SIZE)) begin
            if (room) nxt.written_count = st.written_count + COUNT_W'(1);
            else nxt.overflow_seen = 1'b1;
            nxt.size_or_remaining = size_dec;
            nxt.phase = (size_dec == '0) ? PH_SKIP_DATA : PH_DATA;
          end
        end
        default: begin
          if (is_nul) begin
            nxt.finished = 1'b1;
          end else if (!crlf) begin
            nxt.size_or_remaining = {{(SIZE_W-4){1'b0}}, digit};
            nxt.phase = PH_LINE_IN;
          end
        end
      endcase
    end
  end

  // result
  always_comb begin
    res_valid          = 1'b0;
    res.out_byte       = 8'd0;
    res.is_end         = 1'b0;
    res.saw_zero_chunk = 1'b0;
    res.truncated      = 1'b0;
    if (!st.finished) begin
      case (st.phase)
        PH_LINE_START, PH_LINE_IN: begin
          if (is_nul) begin
            res_valid          = 1'b1;
            res.is_end         = 1'b1;
            res.saw_zero_chunk = (st.phase == PH_LINE_IN) && (st.size_or_remaining == '0);
            res.truncated      = st.overflow_seen;
          end else if (crlf && st.size_or_remaining == '0) begin
            res_valid          = 1'b1;
            res.is_end         = 1'b1;
            res.saw_zero_chunk = 1'b1;
            res.truncated      = st.overflow_seen;
          end
        end
        PH_SKIP_SIZE, PH_DATA: begin
          if (is_nul) begin
            res_valid     = 1'b1;
            res.is_end    = 1'b1;
            res.truncated = st.overflow_seen;
          end else if (!(crlf && st.phase == PH_SKIP_SIZE) && room) begin
            res_valid    = 1'b1;
            res.out_byte = c;
          end
        end
        default: begin
          if (is_nul) begin
            res_valid     = 1'b1;
            res.is_end    = 1'b1;
            res.truncated = st.overflow_seen;
          end
        end
      endcase
    end
  end

endmodule

// ----- design/http_chunked_body_decoder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top
// Decodes an HTTP chunked body, one byte per request, into payload bytes.
// ----------------------------------------------------------------------------
// usage
//   in channel: one body byte per request (in_valid / in_ready / in_data);
//   start_of_body set on the first byte of a body clears the decoder first
//   out channel: payload bytes, then a single end request (is_end set) that
//   carries saw_zero_chunk and truncated; size lines and crlf produce nothing
//   config: cfg_wr_en / cfg_wr_data write the output capacity; write it only
//   while idle, it takes effect on the next byte
// timing
//   one byte per cycle while the output side keeps accepting; the byte is
//   decoded in the cycle it is taken and its result is registered in the
//   output register; the state update is one pass through hcbd_step
// reset
//   rst (synchronous) clears the decoder state, empties the output register
//   and sets capacity back to 131072
// stall
//   while the output register holds an unaccepted request, in_ready drops,
//   so nothing is lost; bytes that give no result still need a free slot
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_top
  import hcbd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data
);

  // capacity is kept as the largest payload count allowed (capacity - 1),
  // clamped to the legal range at write time
  logic [COUNT_W-1:0] cap_limit;
  logic [COUNT_W-1:0] cap_limit_next;

  dec_state_t dec_state;
  dec_state_t dec_state_next;
  logic       step_valid;
  out_item_t  step_res;
  logic       in_fire;

  // output slot frees up when it is empty or being drained this cycle
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    if (cfg_wr_data == '0) begin
      cap_limit_next = '0;
    end else if (cfg_wr_data > CAP_MAX) begin
      cap_limit_next = CAP_LIMIT_MAX;
    end else begin
      cap_limit_next = COUNT_W'(cfg_wr_data - CAP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_limit <= CAP_LIMIT_MAX;
    end else if (cfg_wr_en) begin
      cap_limit <= cap_limit_next;
    end
  end

  hcbd_step u_step (
    .cur       (dec_state),
    .item      (in_data),
    .cap_limit (cap_limit),
    .nxt       (dec_state_next),
    .res_valid (step_valid),
    .res       (step_res)
  );

  // decoder state advances on every accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      dec_state <= STATE_CLEAR;
    end else if (in_fire) begin
      dec_state <= dec_state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= step_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && step_valid) begin
      out_data <= step_res;
    end
  end

  // an end result always leaves the decoder finished
  a_end_sets_finished: assert property (@(posedge clk) disable iff (rst)
    (in_fire && step_valid && step_res.is_end) |=> dec_state.finished)
    else $error("end result without finished state");

  // once finished, only a new body can produce results
  a_quiet_after_end: assert property (@(posedge clk) disable iff (rst)
    (dec_state.finished && !in_data.start_of_body) |-> !step_valid)
    else $error("result after end of decoding");

  // payload results carry no end flags
  a_payload_flags: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.is_end) |-> (!out_data.saw_zero_chunk && !out_data.truncated))
    else $error("payload request with end flags");

  // chunk data phase never runs with nothing left to take
  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    (dec_state.phase == PH_DATA) |-> (dec_state.size_or_remaining != '0))
    else $error("data phase with zero remaining");

endmodule
